[hdl/v3n_pkg.sv]
`default_nettype none
package v3n_pkg;

   localparam int CompWidth  = 32;
   localparam int UnitFrac   = 30;
   localparam int RootSteps  = 32;
   localparam int DivSteps   = 31;
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);

   // front result: exact sum of squares plus what the divider needs
   typedef struct packed {
      logic [63:0]       sum;
      logic [2:0][31:0]  mag;
      logic [2:0]        neg;
      logic              zero;
   } item_type;

   typedef struct packed {
      logic [63:0]       v;
      logic [35:0]       rem;
      logic [31:0]       root;
      logic [2:0][31:0]  mag;
      logic [2:0]        neg;
      logic              zero;
   } root_stage_type;

   typedef struct packed {
      logic [31:0]       len;
      logic [2:0][31:0]  r;
      logic [2:0][30:0]  q;
      logic [2:0][30:0]  nb;
      logic [2:0]        neg;
      logic              zero;
   } div_stage_type;

endpackage
`default_nettype wire

[hdl/v3n_if.sv]
`default_nettype none
interface v3n_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] x_in;
   logic signed [31:0] y_in;
   logic signed [31:0] z_in;
   modport source (output valid, output x_in, output y_in, output z_in, input ready);
   modport sink (input valid, input x_in, input y_in, input z_in, output ready);
endinterface

interface v3n_rsp_if;
   logic               valid;
   logic               ready;
   logic [31:0]        length_out;
   logic signed [31:0] unit_x;
   logic signed [31:0] unit_y;
   logic signed [31:0] unit_z;
   logic               zero_vector;
   modport source (output valid, output length_out, output unit_x, output unit_y,
                   output unit_z, output zero_vector, input ready);
   modport sink (input valid, input length_out, input unit_x, input unit_y,
                 input unit_z, input zero_vector, output ready);
endinterface
`default_nettype wire

[hdl/vector3_normalize.sv]
// vector3_normalize: length and unit vector of a signed Q15.16 3-D vector
//
// req_ch carries x_in, y_in, z_in; rsp_ch returns length_out (Q16.16),
// unit_x/y/z (Q1.30, truncated toward zero) and zero_vector. A beat moves
// when valid and ready are both high.
//
// One vector is taken every cycle unless the front is stalled by a full
// queue. An accepted req beat passes the front registers (magnitude,
// squares, sum), the queue (write, registered read), a 32-stage square-root
// pipeline retiring one root bit per stage, a 31-stage restoring divider per
// component retiring one quotient bit per stage, and the output register.
//
// The front and the back each stall on their own, joined by a 4-entry
// queue with a head register. When the receiver holds ready low the back
// freezes in place and the result stays on rsp_ch; the front keeps taking
// beats until the queue fills, then drops req_ch.ready.
//
// Reset (synchronous, active high) empties all stages and the queue.
// A null vector gives zero_vector = 1 with length and unit fields zero.
`default_nettype none
module vector3_normalize (
   input  wire logic clock,
   input  wire logic reset,
   v3n_req_if.sink   req_ch,
   v3n_rsp_if.source rsp_ch
);
   import v3n_pkg::*;

   logic     f_valid, f_ready, q_valid, q_ready;
   item_type f_item, q_item;

   v3n_front u_front (
      .clock(clock), .reset(reset), .req_ch(req_ch),
      .out_valid(f_valid), .out_item(f_item), .out_ready(f_ready)
   );

   v3n_queue u_queue (
      .clock(clock), .reset(reset),
      .push_valid(f_valid), .push_item(f_item), .push_ready(f_ready),
      .pop_valid(q_valid), .pop_item(q_item), .pop_ready(q_ready)
   );

   v3n_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_item(q_item), .in_ready(q_ready), .rsp_ch(rsp_ch)
   );

   a_null_zeros : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.zero_vector |->
         rsp_ch.length_out == 0 && rsp_ch.unit_x == 0 && rsp_ch.unit_y == 0 &&
         rsp_ch.unit_z == 0)
      else $error("null vector gave non-zero fields");

   a_len_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.zero_vector |-> rsp_ch.length_out != 0)
      else $error("non-null vector gave zero length");

   a_unit_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |->
         rsp_ch.unit_x <= 32'sd1073741824 && rsp_ch.unit_x >= -32'sd1073741824 &&
         rsp_ch.unit_y <= 32'sd1073741824 && rsp_ch.unit_y >= -32'sd1073741824 &&
         rsp_ch.unit_z <= 32'sd1073741824 && rsp_ch.unit_z >= -32'sd1073741824)
      else $error("unit component beyond one");
endmodule
`default_nettype wire

[hdl/v3n_front.sv]
`default_nettype none
module v3n_front (
   input  wire logic        clock,
   input  wire logic        reset,
   v3n_req_if.sink          req_ch,
   output logic             out_valid,
   output v3n_pkg::item_type out_item,
   input  wire logic        out_ready
);
   import v3n_pkg::*;

   logic                    en;
   logic                    a_vld_ff, b_vld_ff, c_vld_ff;
   logic [2:0][31:0]        a_mag_ff, a_mag_in;
   logic [2:0]              a_neg_ff, a_neg_in;
   logic [2:0][31:0]        b_mag_ff;
   logic [2:0]              b_neg_ff;
   logic [2:0][63:0]        b_sq_ff, b_sq_in;
   item_type                c_item_ff, c_item_in;
   logic [2:0][CompWidth-1:0] comp;

   assign en           = !c_vld_ff || out_ready;
   assign req_ch.ready = en;
   assign out_valid    = c_vld_ff;
   assign out_item     = c_item_ff;

   assign comp[0] = req_ch.x_in[CompWidth-1:0];
   assign comp[1] = req_ch.y_in[CompWidth-1:0];
   assign comp[2] = req_ch.z_in[CompWidth-1:0];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_neg_in[i] = comp[i][CompWidth-1];
         a_mag_in[i] = 32'(a_neg_in[i] ? (~comp[i] + 1'b1) : comp[i]);
         b_sq_in[i]  = 64'(a_mag_ff[i]) * 64'(a_mag_ff[i]);
      end
      c_item_in.sum  = b_sq_ff[0] + b_sq_ff[1] + b_sq_ff[2];
      c_item_in.mag  = b_mag_ff;
      c_item_in.neg  = b_neg_ff;
      c_item_in.zero = ~|b_mag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= req_ch.valid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_mag_ff  <= a_mag_in;
         a_neg_ff  <= a_neg_in;
         b_mag_ff  <= a_mag_ff;
         b_neg_ff  <= a_neg_ff;
         b_sq_ff   <= b_sq_in;
         c_item_ff <= c_item_in;
      end
   end
endmodule
`default_nettype wire

[hdl/v3n_queue.sv]
`default_nettype none
module v3n_queue (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push_valid,
   input  v3n_pkg::item_type push_item,
   output logic              push_ready,
   output logic              pop_valid,
   output v3n_pkg::item_type pop_item,
   input  wire logic         pop_ready
);
   import v3n_pkg::*;

   item_type               mem_ff [QueueDepth];
   item_type               head_ff;
   logic [QueuePtrW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QueuePtrW:0]     cnt_ff, cnt_in;
   logic                   head_vld_ff, head_vld_in;
   logic                   do_push, do_pop, do_load;

   assign push_ready = cnt_ff != (QueuePtrW+1)'(QueueDepth);
   assign pop_valid  = head_vld_ff;
   assign pop_item   = head_ff;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   // refill the head register whenever an entry waits and the head is empty or its beat leaves
   assign do_load    = (cnt_ff != '0) && (!head_vld_ff || pop_ready);

   always_comb begin
      wr_in       = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in       = do_load ? rd_ff + 1'b1 : rd_ff;
      cnt_in      = cnt_ff + (QueuePtrW+1)'(do_push) - (QueuePtrW+1)'(do_load);
      head_vld_in = do_load ? 1'b1 : (do_pop ? 1'b0 : head_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff       <= '0;
         rd_ff       <= '0;
         cnt_ff      <= '0;
         head_vld_ff <= 1'b0;
      end else begin
         wr_ff       <= wr_in;
         rd_ff       <= rd_in;
         cnt_ff      <= cnt_in;
         head_vld_ff <= head_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_item;
      if (do_load) head_ff <= mem_ff[rd_ff];
   end
endmodule
`default_nettype wire

[hdl/v3n_back.sv]
`default_nettype none
module v3n_back (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   input  v3n_pkg::item_type in_item,
   output logic              in_ready,
   v3n_rsp_if.source         rsp_ch
);
   import v3n_pkg::*;

   function automatic root_stage_type root_step(root_stage_type s);
      root_stage_type n;
      logic [35:0]    rem2, trial;
      n     = s;
      rem2  = {s.rem[33:0], s.v[63:62]};
      trial = {2'b00, s.root, 2'b01};
      n.v   = {s.v[61:0], 2'b00};
      if (rem2 >= trial) begin
         n.rem  = rem2 - trial;
         n.root = {s.root[30:0], 1'b1};
      end else begin
         n.rem  = rem2;
         n.root = {s.root[30:0], 1'b0};
      end
      return n;
   endfunction

   function automatic div_stage_type div_step(div_stage_type s);
      div_stage_type n;
      logic [32:0]   t;
      n = s;
      for (int i = 0; i < 3; i++) begin
         t       = {s.r[i], s.nb[i][30]};
         n.nb[i] = {s.nb[i][29:0], 1'b0};
         if (t >= {1'b0, s.len}) begin
            n.r[i] = 32'(t - {1'b0, s.len});
            n.q[i] = {s.q[i][29:0], 1'b1};
         end else begin
            n.r[i] = t[31:0];
            n.q[i] = {s.q[i][29:0], 1'b0};
         end
      end
      return n;
   endfunction

   logic            en;
   root_stage_type  rt_ff [RootSteps+1];
   logic            rt_vld_ff [RootSteps+1];
   div_stage_type   dv_ff [DivSteps+1];
   logic            dv_vld_ff [DivSteps+1];
   root_stage_type  rt_head;
   div_stage_type   dv_head;
   logic            out_vld_ff;
   logic [31:0]     len_ff, len_in;
   logic [2:0][31:0] unit_ff, unit_in;
   logic            zero_ff, zero_in;

   assign en       = !out_vld_ff || rsp_ch.ready;
   assign in_ready = en;

   always_comb begin
      rt_head.v    = in_item.sum;
      rt_head.rem  = '0;
      rt_head.root = '0;
      rt_head.mag  = in_item.mag;
      rt_head.neg  = in_item.neg;
      rt_head.zero = in_item.zero;
      dv_head.len  = rt_ff[RootSteps].root;
      dv_head.neg  = rt_ff[RootSteps].neg;
      dv_head.zero = rt_ff[RootSteps].zero;
      for (int i = 0; i < 3; i++) begin
         // quotient fits 31 bits, so the top of the dividend starts the remainder
         dv_head.r[i]  = {1'b0, rt_ff[RootSteps].mag[i][31:1]};
         dv_head.nb[i] = {rt_ff[RootSteps].mag[i][0], 30'd0};
         dv_head.q[i]  = '0;
      end
      len_in  = dv_ff[DivSteps].zero ? 32'd0 : dv_ff[DivSteps].len;
      zero_in = dv_ff[DivSteps].zero;
      for (int i = 0; i < 3; i++) begin
         if (dv_ff[DivSteps].zero) unit_in[i] = '0;
         else if (dv_ff[DivSteps].neg[i]) unit_in[i] = ~{1'b0, dv_ff[DivSteps].q[i]} + 1'b1;
         else unit_in[i] = {1'b0, dv_ff[DivSteps].q[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= RootSteps; k++) rt_vld_ff[k] <= 1'b0;
         for (int k = 0; k <= DivSteps; k++) dv_vld_ff[k] <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         rt_vld_ff[0] <= in_valid;
         for (int k = 0; k < RootSteps; k++) rt_vld_ff[k+1] <= rt_vld_ff[k];
         dv_vld_ff[0] <= rt_vld_ff[RootSteps];
         for (int k = 0; k < DivSteps; k++) dv_vld_ff[k+1] <= dv_vld_ff[k];
         out_vld_ff <= dv_vld_ff[DivSteps];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rt_ff[0] <= rt_head;
         for (int k = 0; k < RootSteps; k++) rt_ff[k+1] <= root_step(rt_ff[k]);
         dv_ff[0] <= dv_head;
         for (int k = 0; k < DivSteps; k++) dv_ff[k+1] <= div_step(dv_ff[k]);
         len_ff  <= len_in;
         unit_ff <= unit_in;
         zero_ff <= zero_in;
      end
   end

   assign rsp_ch.valid       = out_vld_ff;
   assign rsp_ch.length_out  = len_ff;
   assign rsp_ch.unit_x      = unit_ff[0];
   assign rsp_ch.unit_y      = unit_ff[1];
   assign rsp_ch.unit_z      = unit_ff[2];
   assign rsp_ch.zero_vector = zero_ff;
endmodule
`default_nettype wire

[tb/vector3_normalize_checker.sv]
`default_nettype none
module vector3_normalize_checker (
   input  wire logic clock,
   input  wire logic reset,
   v3n_req_if        req_mon,
   v3n_rsp_if        rsp_mon,
   output int        mismatches,
   output int        pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0]        length_out;
      logic signed [31:0] unit_x;
      logic signed [31:0] unit_y;
      logic signed [31:0] unit_z;
      logic               zero_vector;
   } norm_result_type;

   norm_result_type expected_norms[$];

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] b;
      rem = v;
      root = 0;
      b = 64'd1 << 62;
      while (b > rem) b = b >> 2;
      while (b != 0) begin
         if (rem >= root + b) begin
            rem = rem - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root;
   endfunction

   function automatic logic [31:0] unit_of(input logic signed [31:0] c,
                                           input logic [63:0] len);
      logic [63:0] mag;
      logic [63:0] q;
      mag = c[31] ? 64'(-64'(signed'(c))) : 64'(c);
      q = (mag << 30) / len;
      if (c[31]) q = -q;
      return q[31:0];
   endfunction

   function automatic norm_result_type normalize(input logic signed [31:0] x,
                                                 input logic signed [31:0] y,
                                                 input logic signed [31:0] z);
      norm_result_type r;
      logic [63:0] mx, my, mz, sum, len;
      mx = x[31] ? 64'(-64'(signed'(x))) : 64'(x);
      my = y[31] ? 64'(-64'(signed'(y))) : 64'(y);
      mz = z[31] ? 64'(-64'(signed'(z))) : 64'(z);
      sum = mx * mx + my * my + mz * mz;
      r = '0;
      if (sum == 0) begin
         r.zero_vector = 1'b1;
      end else begin
         len = int_sqrt(sum);
         r.length_out = len[31:0];
         r.unit_x = unit_of(x, len);
         r.unit_y = unit_of(y, len);
         r.unit_z = unit_of(z, len);
      end
      return r;
   endfunction

   initial mismatches = 0;
   assign pending = expected_norms.size();

   always @(posedge clock) begin
      norm_result_type got, want;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready)
            expected_norms.push_back(normalize(req_mon.x_in, req_mon.y_in, req_mon.z_in));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.length_out, rsp_mon.unit_x, rsp_mon.unit_y,
                   rsp_mon.unit_z, rsp_mon.zero_vector};
            if (expected_norms.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected rsp beat: len=%0d ux=%0d uy=%0d uz=%0d zero=%0b",
                           got.length_out, got.unit_x, got.unit_y, got.unit_z,
                           got.zero_vector);
            end else begin
               want = expected_norms.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: exp len=%0d u=%0d,%0d,%0d z=%0b",
                               " got len=%0d u=%0d,%0d,%0d z=%0b"},
                              want.length_out, want.unit_x, want.unit_y, want.unit_z,
                              want.zero_vector, got.length_out, got.unit_x,
                              got.unit_y, got.unit_z, got.zero_vector);
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

[tb/vector3_normalize_tb.sv]
`default_nettype none
module vector3_normalize_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RandomVectors = 1700;
   localparam int StallLimit    = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   mismatches;
   int   pending;
   int   idle_cycles = 0;
   bit   stim_done = 1'b0;

   v3n_req_if req_ch();
   v3n_rsp_if rsp_ch();

   vector3_normalize dut (.clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch));

   vector3_normalize_checker checker_i (
      .clock(clock), .reset(reset), .req_mon(req_ch), .rsp_mon(rsp_ch),
      .mismatches(mismatches), .pending(pending)
   );

   always #5 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.x_in = '0;
      req_ch.y_in = '0;
      req_ch.z_in = '0;
      rsp_ch.ready = 1'b0;
   end

   function automatic logic [31:0] pick_component();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '0;
         3: return 32'($signed($urandom_range(0, 600000)) - 300000);
         4: return 32'($signed($urandom_range(0, 1000)) - 500);
         default: return $urandom;
      endcase
   endfunction

   // valid stays high between beats sent back to back
   task automatic send_vector(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input bit gap);
      int wait_cycles;
      wait_cycles = gap ? $urandom_range(0, 14) : 0;
      if (wait_cycles > 0) begin
         req_ch.valid <= 1'b0;
         repeat (wait_cycles) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.x_in <= x;
      req_ch.y_in <= y;
      req_ch.z_in <= z;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // receiver stalls drawn per beat, more often none once stimulus is done or the bus is idle
   initial begin
      int stall;
      @(negedge clock);
      wait (!reset);
      forever begin
         stall = (stim_done || idle_cycles > 0) && $urandom_range(0, 3) == 0 ?
                 0 : $urandom_range(0, 14);
         rsp_ch.ready <= 1'b0;
         repeat (stall) @(negedge clock);
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // null vector, extremes, axis vectors, single lsb
      send_vector(0, 0, 0, 0);
      send_vector(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0);
      send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
      send_vector(32'h8000_0000, 0, 0, 0);
      send_vector(0, 32'h8000_0000, 0, 0);
      send_vector(0, 0, 32'h7fff_ffff, 0);
      send_vector(1, 0, 0, 0);
      send_vector(0, 32'hffff_ffff, 0, 0);
      send_vector(0, 0, 1, 0);
      send_vector(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0);
      send_vector(32'h0003_0000, 32'h0004_0000, 0, 0);
      send_vector(32'h8000_0000, 32'h7fff_ffff, 1, 0);
      send_vector(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0);
      send_vector(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f, 0);
      for (int i = 0; i < RandomVectors; i++) begin
         send_vector(pick_component(), pick_component(), pick_component(),
                     (i / 200) % 2 == 1);
         if (i == RandomVectors / 2) begin
            req_ch.valid <= 1'b0;
            wait (pending == 0);
            @(negedge clock);
         end
      end
      req_ch.valid <= 1'b0;
      stim_done = 1'b1;
      wait (pending == 0);
      repeat (100) @(posedge clock);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
`default_nettype wire
